@@ hdl/encoder_speed_pi_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Encoder speed PI controller: assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_PI_CONTROLLER_DEFINES_SVH
`define ENCODER_SPEED_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define ECPI_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ECPI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ecpi_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder speed PI controller package
// Configuration layout, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package ecpi_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_SPEED_NUMERATOR = 2'd0;
   localparam logic [1:0] CSR_TARGET_SPEED    = 2'd1;
   localparam logic [1:0] CSR_KP              = 2'd2;
   localparam logic [1:0] CSR_KI              = 2'd3;

   localparam int NUM_W    = 20;
   localparam int TARGET_W = 16;
   localparam int KP_W     = 12;
   localparam int KI_W     = 16;
   localparam int CSR_W    = 20;

   // Reset values
   localparam logic [NUM_W-1:0]    NUMERATOR_RESET = 20'd96510;
   localparam logic [TARGET_W-1:0] TARGET_RESET    = 16'd8192;
   localparam logic [KP_W-1:0]     KP_RESET        = 12'd300;
   localparam logic [KI_W-1:0]     KI_RESET        = 16'd0;

   // Duty and term limit
   localparam logic [9:0] DUTY_LIMIT = 10'd1023;

   typedef struct packed {
      logic [NUM_W-1:0]    speed_numerator;
      logic [TARGET_W-1:0] target_speed;
      logic [KP_W-1:0]     kp;
      logic [KI_W-1:0]     ki;
   } ecpi_cfg_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } ecpi_qstat_type;

endpackage

@@ hdl/ecpi_req_if.sv @@
// ----------------------------------------------------------------------------
// Encoder sample channel
// Valid/ready channel carrying one sampled encoder level per item.
// ----------------------------------------------------------------------------
interface ecpi_req_if;
   logic valid;
   logic ready;
   logic encoder_level;

   modport source (output valid, output encoder_level, input ready);
   modport sink   (input valid, input encoder_level, output ready);
endinterface

@@ hdl/ecpi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Speed result channel
// Valid/ready channel carrying speed, period and new PWM duty.
// ----------------------------------------------------------------------------
interface ecpi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] speed;
   logic [15:0] period_ticks;
   logic [9:0]  pwm_duty;

   modport source (output valid, output speed, output period_ticks, output pwm_duty,
                   input ready);
   modport sink   (input valid, input speed, input period_ticks, input pwm_duty,
                   output ready);
endinterface

@@ hdl/ecpi_queue.sv @@
// ----------------------------------------------------------------------------
// Period queue
// Two-entry FIFO of measured periods between the front and back parts.
// ----------------------------------------------------------------------------
`include "encoder_speed_pi_controller_defines.svh"

module ecpi_queue
   import ecpi_pkg::*;
#(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  logic [W-1:0]   push_data,
   input  logic           pop,
   output logic [W-1:0]   pop_data,
   output ecpi_qstat_type stat
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   `ECPI_ASSERT_IMPLY(a_queue_no_underflow, pop, !stat.empty, "pop from empty period queue")

endmodule

@@ hdl/ecpi_front.sv @@
// ----------------------------------------------------------------------------
// Encoder edge front end
// Accepts level samples, tracks the timing window and queues valid periods.
// ----------------------------------------------------------------------------
`include "encoder_speed_pi_controller_defines.svh"

module ecpi_front
   import ecpi_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ecpi_req_if.sink              req_ch,
   input  ecpi_qstat_type        qstat,
   output logic                  push,
   output logic [COUNT_BITS-1:0] push_data
);

   localparam logic [COUNT_BITS-1:0] STEADY_MAX = {{(COUNT_BITS-1){1'b1}}, 1'b0};

   logic                  last_ff, last_in;
   logic                  active_ff, active_in;
   logic [COUNT_BITS-1:0] steady_ff, steady_in;
   logic                  accept;
   logic                  closed;

   assign req_ch.ready = !qstat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_data    = steady_ff + COUNT_BITS'(1);

   // Window tracking per accepted item
   always_comb begin
      last_in   = last_ff;
      active_in = active_ff;
      steady_in = steady_ff;
      closed    = 1'b0;
      push      = 1'b0;
      if (accept) begin
         if (req_ch.encoder_level != last_ff) begin
            if (!active_ff) begin
               active_in = 1'b1;
            end else begin
               active_in = 1'b0;
               closed    = 1'b1;
            end
         end else if (active_ff && (steady_ff != STEADY_MAX)) begin
            steady_in = steady_ff + COUNT_BITS'(1);
         end
         last_in = req_ch.encoder_level;
         // empty window is dropped and keeps its count at zero
         if (closed && (steady_ff != '0)) begin
            push      = 1'b1;
            steady_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 1'b0;
         active_ff <= 1'b0;
         steady_ff <= '0;
      end else begin
         last_ff   <= last_in;
         active_ff <= active_in;
         steady_ff <= steady_in;
      end
   end

   `ECPI_ASSERT_NEXT(a_push_closes_window, push, !active_ff, "period queued with window open")
   `ECPI_ASSERT_IMPLY(a_push_has_room, push, !qstat.full, "period pushed into full queue")

endmodule

@@ hdl/ecpi_back.sv @@
// ----------------------------------------------------------------------------
// Speed and PI back end
// Divides the numerator by the period, then runs one PI step per period.
// ----------------------------------------------------------------------------
`include "encoder_speed_pi_controller_defines.svh"

module ecpi_back
   import ecpi_pkg::*;
#(
   parameter int COUNT_BITS      = 16,
   parameter int SPEED_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ecpi_cfg_type          cfg,
   input  ecpi_qstat_type        qstat,
   input  logic [COUNT_BITS-1:0] pop_data,
   output logic                  pop,
   ecpi_rsp_if.source            rsp_ch
);

   localparam int I_SHIFT = SPEED_FRAC_BITS + 10;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int MAG_W   = 16 + COUNT_BITS;
   localparam int PROD_W  = MAG_W + KI_W;
   localparam int QM_W    = 63 - I_SHIFT;
   localparam int Q_W     = QM_W + 1;
   localparam int SUM_W   = Q_W + 1;

   localparam logic [63:0]            PROD_SAT = 64'h4000_0000_0000_0000;
   localparam logic [62:0]            ROUND    = 63'((64'd1 << I_SHIFT) - 64'd1);
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_SPD  = 3'd2;
   localparam logic [2:0] S_MUL1 = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_QST  = 3'd5;
   localparam logic [2:0] S_SUM  = 3'd6;
   localparam logic [2:0] S_DUTY = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]   period_ff, period_in;
   logic [COUNT_BITS:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [15:0]             speed_ff, speed_in;
   logic signed [16:0]      err_ff, err_in;
   logic signed [29:0]      pprod_ff, pprod_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [62:0]             prod_ff, prod_in;
   logic signed [10:0]      pterm_ff, pterm_in;
   logic signed [Q_W-1:0]   qterm_ff, qterm_in;
   logic signed [31:0]      integral_ff, integral_in;
   logic                    out_valid_ff, out_valid_in;
   logic [15:0]             out_speed_ff, out_speed_in;
   logic [15:0]             out_period_ff, out_period_in;
   logic [9:0]              out_duty_ff, out_duty_in;

   logic [COUNT_BITS:0]     rem_shift;
   logic                    rem_ge;
   logic [15:0]             speed_sat;
   logic [15:0]             err_abs;
   logic [PROD_W-1:0]       prod_full;
   logic signed [29:0]      pshift;
   logic [62:0]             prod_round;
   logic [QM_W-1:0]         qmag;
   logic signed [SUM_W-1:0] sum;
   logic signed [10:0]      iterm;
   logic signed [11:0]      total;
   logic [11:0]             total_abs;
   logic                    out_free;

   // Restoring divide step
   assign rem_shift = {rem_ff[COUNT_BITS-1:0], quo_ff[NUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, period_ff});

   assign speed_sat = (quo_ff > NUM_W'(16'hFFFF)) ? 16'hFFFF : quo_ff[15:0];
   assign err_abs   = err_ff[16] ? 16'(-err_ff) : 16'(err_ff);
   assign prod_full = mag_ff * cfg.ki;
   assign pshift    = pprod_ff >>> SPEED_FRAC_BITS;

   // Ceiling shift of the magnitude for negative errors gives floor of the value
   assign prod_round = err_ff[16] ? (prod_ff + ROUND) : prod_ff;
   assign qmag       = prod_round[62:I_SHIFT];

   assign sum = SUM_W'(integral_ff) + SUM_W'(qterm_ff);

   // Output terms
   always_comb begin
      if (integral_ff > 32'sd1023) begin
         iterm = 11'sd1023;
      end else if (integral_ff < -32'sd1023) begin
         iterm = -11'sd1023;
      end else begin
         iterm = 11'(integral_ff);
      end
      total     = 12'(pterm_ff) + 12'(iterm);
      total_abs = total[11] ? 12'(-total) : 12'(total);
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign pop      = (state_ff == S_IDLE) && !qstat.empty;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      period_in     = period_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      speed_in      = speed_ff;
      err_in        = err_ff;
      pprod_in      = pprod_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      pterm_in      = pterm_ff;
      qterm_in      = qterm_ff;
      integral_in   = integral_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_speed_in  = out_speed_ff;
      out_period_in = out_period_ff;
      out_duty_in   = out_duty_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               period_in = pop_data;
               rem_in    = '0;
               quo_in    = cfg.speed_numerator;
               cnt_in    = '0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = rem_ge ? (rem_shift - {1'b0, period_ff}) : rem_shift;
            quo_in = {quo_ff[NUM_W-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            speed_in = speed_sat;
            err_in   = $signed({1'b0, cfg.target_speed}) - $signed({1'b0, speed_sat});
            state_in = S_MUL1;
         end
         S_MUL1: begin
            pprod_in = err_ff * $signed({1'b0, cfg.kp});
            mag_in   = err_abs * period_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in = (64'(prod_full) > PROD_SAT) ? 63'(PROD_SAT) : 63'(prod_full);
            if (pshift > 30'sd1023) begin
               pterm_in = 11'sd1023;
            end else if (pshift < -30'sd1023) begin
               pterm_in = -11'sd1023;
            end else begin
               pterm_in = 11'(pshift);
            end
            state_in = S_QST;
         end
         S_QST: begin
            qterm_in = err_ff[16] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sum > SUM_MAX) begin
               integral_in = 32'(SUM_MAX);
            end else if (sum < SUM_MIN) begin
               integral_in = 32'(SUM_MIN);
            end else begin
               integral_in = 32'(sum);
            end
            state_in = S_DUTY;
         end
         S_DUTY: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_speed_in  = speed_ff;
               out_period_in = (33'(period_ff) > 33'(16'hFFFF)) ? 16'hFFFF
                                                                 : 16'(period_ff);
               out_duty_in   = (total_abs > 12'(DUTY_LIMIT)) ? DUTY_LIMIT
                                                             : total_abs[9:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         integral_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integral_ff  <= integral_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      period_ff     <= period_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      speed_ff      <= speed_in;
      err_ff        <= err_in;
      pprod_ff      <= pprod_in;
      mag_ff        <= mag_in;
      prod_ff       <= prod_in;
      pterm_ff      <= pterm_in;
      qterm_ff      <= qterm_in;
      out_speed_ff  <= out_speed_in;
      out_period_ff <= out_period_in;
      out_duty_ff   <= out_duty_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.speed        = out_speed_ff;
   assign rsp_ch.period_ticks = out_period_ff;
   assign rsp_ch.pwm_duty     = out_duty_ff;

   `ECPI_ASSERT_IMPLY(a_result_ends_item, $rose(out_valid_ff), state_ff == S_IDLE, "result without return to idle")

endmodule

@@ hdl/encoder_speed_pi_controller.sv @@
// A valid period is pushed into the period queue when the item that closes its window is accepted.
// Throughput: one encoder item per cycle while the two-entry period queue has room.
// The back end pops a period only in idle, then runs the 20-step restoring divider and the PI states.
// A window needs at least three items, so closely spaced windows fill the queue and stall input.
// Reset: synchronous, active high; clears window state, integral and queue,
// and returns the registers to their documented defaults.
// ----------------------------------------------------------------------------
// Encoder speed PI controller
// Measures the encoder half period and updates the PWM duty with a PI step.
// ----------------------------------------------------------------------------
module encoder_speed_pi_controller
   import ecpi_pkg::*;
#(
   parameter int COUNT_BITS      = 16,
   parameter int SPEED_FRAC_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   ecpi_req_if.sink         req_ch,
   ecpi_rsp_if.source       rsp_ch,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   ecpi_cfg_type          cfg_ff, cfg_in;
   ecpi_qstat_type        qstat;
   logic                  push;
   logic                  pop;
   logic [COUNT_BITS-1:0] push_data;
   logic [COUNT_BITS-1:0] pop_data;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SPEED_NUMERATOR: cfg_in.speed_numerator = csr_wdata[NUM_W-1:0];
            CSR_TARGET_SPEED:    cfg_in.target_speed    = csr_wdata[TARGET_W-1:0];
            CSR_KP:              cfg_in.kp              = csr_wdata[KP_W-1:0];
            CSR_KI:              cfg_in.ki              = csr_wdata[KI_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_numerator <= NUMERATOR_RESET;
         cfg_ff.target_speed    <= TARGET_RESET;
         cfg_ff.kp              <= KP_RESET;
         cfg_ff.ki              <= KI_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ecpi_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   ecpi_queue #(
      .W (COUNT_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (qstat)
   );

   ecpi_back #(
      .COUNT_BITS      (COUNT_BITS),
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .qstat    (qstat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder speed PI controller testbench
// Feeds sampled encoder levels through the request channel and checks every
// speed, period and duty item against an in-bench model of the measurement
// window and PI step, or against a directed row's own values. A short table
// of directed rows runs first, then several phases of random register settings
// and random level runs; both channels idle at random until the last phase.
// ----------------------------------------------------------------------------
module testbench;
   import ecpi_pkg::*;

   localparam int          SPEED_FRAC   = 12;
   localparam int unsigned STEADY_CAP   = 65534;
   localparam longint      TERM_LIMIT   = longint'(DUTY_LIMIT);
   localparam longint      ACC_MAX      = 2147483647;
   localparam longint      ACC_MIN      = -ACC_MAX - 1;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          PHASE_ITEMS  = 120;
   localparam int          PHASE_COUNT  = 6;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] period_ticks;
      logic [9:0]  pwm_duty;
   } speed_rec_type;

   typedef enum logic [0:0] {ROW_LEVEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       reg_idx;
      logic [CSR_W-1:0] value;
      int               count;
      bit               typed;
      speed_rec_type    want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_en;
   logic [1:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;

   ecpi_req_if req_ch ();
   ecpi_rsp_if rsp_ch ();

   encoder_speed_pi_controller uut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // Model state
   ecpi_cfg_type  model_cfg;
   bit            last_lvl;
   bit            window_open;
   int unsigned   steady_cnt;
   longint        integral_acc;

   speed_rec_type speed_results[$];
   stim_row_type  plan[$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   bit            gaps_on = 1'b1;

   task automatic flag_error(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void reset_model();
      model_cfg    = {NUMERATOR_RESET, TARGET_RESET, KP_RESET, KI_RESET};
      last_lvl     = 1'b0;
      window_open  = 1'b0;
      steady_cnt   = 0;
      integral_acc = 0;
   endfunction

   function automatic longint clamp_term(input longint v);
      if (v > TERM_LIMIT) return TERM_LIMIT;
      if (v < -TERM_LIMIT) return -TERM_LIMIT;
      return v;
   endfunction

   // One encoder sample; returns 1 when a valid window closes
   function automatic bit predict_sample(input bit lvl, output speed_rec_type r);
      bit     closed;
      longint per, spd, err, p_term, q_term, sum, total;
      closed = 1'b0;
      r      = '0;
      if (lvl != last_lvl) begin
         closed      = window_open;
         window_open = !window_open;
      end else if (window_open && steady_cnt < STEADY_CAP) begin
         steady_cnt++;
      end
      last_lvl = lvl;
      if (!closed || steady_cnt == 0) return 1'b0;

      per = longint'(steady_cnt) + 1;
      spd = longint'(model_cfg.speed_numerator) / per;
      if (spd > 65535) spd = 65535;
      err    = longint'(model_cfg.target_speed) - spd;
      p_term = clamp_term((err * longint'(model_cfg.kp)) >>> SPEED_FRAC);
      // |err| * period * ki stays below 2^48 at these widths, so no product cap
      q_term = (err * per * longint'(model_cfg.ki)) >>> (SPEED_FRAC + 10);
      sum    = integral_acc + q_term;
      if (sum > ACC_MAX) sum = ACC_MAX;
      if (sum < ACC_MIN) sum = ACC_MIN;
      integral_acc = sum;
      total = p_term + clamp_term(integral_acc);
      if (total < 0) total = -total;
      if (total > TERM_LIMIT) total = TERM_LIMIT;
      steady_cnt = 0;

      r.speed        = spd[15:0];
      r.period_ticks = per[15:0];
      r.pwm_duty     = total[9:0];
      return 1'b1;
   endfunction

   // Drive one level item, predict on acceptance
   task automatic send_level(input bit lvl, input bit typed, input speed_rec_type typed_want);
      speed_rec_type got;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.encoder_level <= lvl;
      do @(posedge clock); while (!req_ch.ready);
      if (predict_sample(lvl, got)) speed_results.push_back(typed ? typed_want : got);
   endtask

   // Block idle: every result out, then the back end latency
   task automatic wait_for_quiet();
      req_ch.valid <= 1'b0;
      while (speed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SPEED_NUMERATOR: model_cfg.speed_numerator = data[NUM_W-1:0];
         CSR_TARGET_SPEED:    model_cfg.target_speed    = data[TARGET_W-1:0];
         CSR_KP:              model_cfg.kp              = data[KP_W-1:0];
         CSR_KI:              model_cfg.ki              = data[KI_W-1:0];
         default: ;
      endcase
   endtask

   // Field value with junk above the register width
   function automatic logic [CSR_W-1:0] pick_reg_value(input int w);
      logic [CSR_W-1:0] mask, field, junk;
      mask = (CSR_W'(1) << w) - 1'b1;
      junk = CSR_W'($urandom());
      case ($urandom_range(0, 3))
         0:       field = '0;
         1:       field = '1;
         default: field = CSR_W'($urandom());
      endcase
      return (junk & ~mask) | (field & mask);
   endfunction

   // Random level runs: mostly clean windows, some noise
   task automatic run_phase(input int n_items);
      int sent;
      int run;
      bit lvl;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               send_level(1'($urandom_range(0, 1)), 1'b0, '0);
               sent++;
            end
         end else begin
            case ($urandom_range(0, 19))
               0:          run = $urandom_range(41, 400);
               1, 2, 3, 4: run = $urandom_range(7, 40);
               default:    run = $urandom_range(1, 6);
            endcase
            if (run > n_items - sent) run = n_items - sent;
            lvl = !last_lvl;
            repeat (run) begin
               send_level(lvl, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   function automatic void build_plan();
      // Defaults after reset; idle ticks, then a period of four
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 3, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 4, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b1, {16'd24127, 16'd4, 10'd1023}});
      // Window closing straight after it opens: dropped
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 1, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b0, '0});
      // Shortest valid period
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 2, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b1, {16'd48255, 16'd2, 10'd1023}});
      // All registers at full scale: speed saturates, zero error
      plan.push_back('{ROW_CSR, CSR_SPEED_NUMERATOR, 20'hFFFFF, 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_TARGET_SPEED, 20'hFFFFF, 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_KP, 20'hFFFFF, 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_KI, 20'hFFFFF, 0, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 2, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b1, {16'd65535, 16'd2, 10'd0}});
      // Zero speed, largest positive error
      plan.push_back('{ROW_CSR, CSR_SPEED_NUMERATOR, 20'd0, 0, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 2, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b1, {16'd0, 16'd2, 10'd1023}});
      // Integral alone drives the duty
      plan.push_back('{ROW_CSR, CSR_TARGET_SPEED, 20'd0, 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_KP, 20'd0, 0, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 3, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b1, {16'd0, 16'd3, 10'd1023}});
      // Largest negative error pulls the integral down
      plan.push_back('{ROW_CSR, CSR_SPEED_NUMERATOR, 20'hFFFFF, 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_KP, 20'hFFFFF, 0, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 2, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b0, '0});
      // Back to defaults, then a long window
      plan.push_back('{ROW_CSR, CSR_SPEED_NUMERATOR, 20'(NUMERATOR_RESET), 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_TARGET_SPEED, 20'(TARGET_RESET), 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_KP, 20'(KP_RESET), 0, 1'b0, '0});
      plan.push_back('{ROW_CSR, CSR_KI, 20'(KI_RESET), 0, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd1, 100, 1'b0, '0});
      plan.push_back('{ROW_LEVEL, '0, 20'd0, 1, 1'b0, '0});
   endfunction

   // Main sequence
   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.encoder_level <= 1'b0;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_SPEED_NUMERATOR;
      csr_wdata            <= '0;
      reset_model();
      build_plan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_for_quiet();
            write_register(plan[i].reg_idx, plan[i].value);
         end else begin
            for (int k = 0; k < plan[i].count; k++)
               send_level(plan[i].value[0], plan[i].typed && k == plan[i].count - 1,
                          plan[i].want);
         end
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_for_quiet();
         write_register(CSR_SPEED_NUMERATOR, pick_reg_value(NUM_W));
         write_register(CSR_TARGET_SPEED, pick_reg_value(TARGET_W));
         write_register(CSR_KP, pick_reg_value(KP_W));
         write_register(CSR_KI, pick_reg_value(KI_W));
         if (ph == PHASE_COUNT - 1) gaps_on = 1'b0;
         run_phase(PHASE_ITEMS);
      end

      wait_for_quiet();
      if (error_count == 0) begin
         $display("PASS encoder_speed_pi_controller");
      end else begin
         $display("FAIL encoder_speed_pi_controller");
      end
      $finish;
   end

   // Result side back-pressure
   initial begin
      forever begin
         if (gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Result check against the oldest expected item
   always @(posedge clock) begin : result_check
      speed_rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (speed_results.size() == 0) begin
            flag_error($sformatf("item with none expected: speed %0d period %0d duty %0d",
                                 rsp_ch.speed, rsp_ch.period_ticks, rsp_ch.pwm_duty));
         end else begin
            want = speed_results.pop_front();
            if (rsp_ch.speed !== want.speed)
               flag_error($sformatf("speed %0d, expected %0d", rsp_ch.speed, want.speed));
            if (rsp_ch.period_ticks !== want.period_ticks)
               flag_error($sformatf("period_ticks %0d, expected %0d",
                                    rsp_ch.period_ticks, want.period_ticks));
            if (rsp_ch.pwm_duty !== want.pwm_duty)
               flag_error($sformatf("pwm_duty %0d, expected %0d",
                                    rsp_ch.pwm_duty, want.pwm_duty));
         end
      end
   end

   // Watchdog: too long without any item moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR %0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("FAIL encoder_speed_pi_controller");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ecpi_pkg.sv
hdl/ecpi_req_if.sv
hdl/ecpi_rsp_if.sv
hdl/ecpi_queue.sv
hdl/ecpi_front.sv
hdl/ecpi_back.sv
hdl/encoder_speed_pi_controller.sv
tb/testbench.sv
